// File: hdl/tcch_pkg.sv
// Shared types, constants and arithmetic helpers of the tilt-compensated compass.
// Used by tcch_cordic, tcch_gain and tilt_compensated_compass_heading.
package tcch_pkg;

	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int ROTATED_WIDTH_DEF = 18;
	localparam int ANG_W             = 32;     // accumulator, units of pi/2^30
	localparam int OP_SHIFT          = 16;     // operand scale 2^16
	localparam int GAIN_LO_W         = 22;     // low slice of the gain multiply
	localparam logic [23:0] KINV     = 24'd10188014;
	localparam logic signed [15:0] QUARTER = 16'sd16384;

	typedef struct packed {
		logic signed [15:0] mag_x;
		logic signed [15:0] mag_y;
		logic signed [15:0] mag_z;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] heading_angle;
	} result_t;

	// atan(2^-i) in units of pi/2^30
	function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned idx);
		logic signed [ANG_W-1:0] t;
		unique case (idx)
			0:  t = 32'sd268435456;
			1:  t = 32'sd158466703;
			2:  t = 32'sd83729454;
			3:  t = 32'sd42502378;
			4:  t = 32'sd21333666;
			5:  t = 32'sd10677233;
			6:  t = 32'sd5339919;
			7:  t = 32'sd2670123;
			8:  t = 32'sd1335082;
			9:  t = 32'sd667543;
			10: t = 32'sd333772;
			11: t = 32'sd166886;
			12: t = 32'sd83443;
			13: t = 32'sd41722;
			14: t = 32'sd20861;
			15: t = 32'sd10430;
			16: t = 32'sd5215;
			17: t = 32'sd2608;
			18: t = 32'sd1304;
			19: t = 32'sd652;
			20: t = 32'sd326;
			21: t = 32'sd163;
			22: t = 32'sd81;
			23: t = 32'sd41;
			default: t = '0;
		endcase
		return t;
	endfunction

	// round to pi/32768 units and clamp to a quarter turn
	function automatic logic signed [15:0] to_angle(input logic signed [ANG_W-1:0] acc);
		logic signed [ANG_W:0] t;
		logic signed [15:0] r;
		t = ($signed({acc[ANG_W-1], acc}) + 33'sd16384) >>> 15;
		if (t > 33'sd16384) begin
			r = QUARTER;
		end else if (t < -33'sd16384) begin
			r = -QUARTER;
		end else begin
			r = 16'(t);
		end
		return r;
	endfunction

endpackage

// File: hdl/tilt_compensated_compass_heading.sv
// Tilt-compensated compass: roll, pitch and heading from one magnetometer/accelerometer set.
// One transfer per cycle is sustained while the result is not stalled, set by the fully
// unrolled CORDIC chains and the two-stage gain multipliers.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
// Reset (arst_n, asynchronous, low) clears every valid bit; data registers are not reset.
// Depends on tcch_pkg, tcch_cordic and tcch_gain.
module tilt_compensated_compass_heading #(
	parameter int CORDIC_STEPS  = tcch_pkg::CORDIC_STEPS_DEF,
	parameter int ROTATED_WIDTH = tcch_pkg::ROTATED_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  tcch_pkg::sample_t sample,
	output logic              result_valid,
	input  logic              result_stall,
	output tcch_pkg::result_t result
);

	localparam int RW = ROTATED_WIDTH;
	// operand width: value, negation, 2^16 scale and CORDIC growth
	localparam int DW = RW + 20;
	localparam int AW = tcch_pkg::ANG_W;
	localparam int SH = tcch_pkg::OP_SHIFT;

	// side data carried alongside each CORDIC chain
	typedef struct packed {
		logic               neg;
		logic               zero;
		logic               num_neg;
		logic               num_pos;
		logic signed [15:0] by;
		logic signed [15:0] bz;
		logic signed [15:0] bx;
		logic signed [15:0] gx;
		logic signed [15:0] gy;
	} sb1_t;

	typedef struct packed {
		logic signed [15:0] roll;
		sb1_t               s;
	} sbg1_t;

	typedef struct packed {
		logic                 zero;
		logic signed [15:0]   roll;
		logic signed [RW-1:0] bfy;
		logic signed [RW-1:0] bz1;
		logic signed [15:0]   bx;
		logic signed [15:0]   gx;
	} sb2_t;

	typedef struct packed {
		logic signed [15:0] pitch;
		sb2_t               s;
	} sbg2_t;

	typedef struct packed {
		logic               zero;
		logic               num_neg;
		logic               num_pos;
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
	} sb3_t;

	logic en;

	// Whole pipeline advances unless a finished result is held by the sink
	assign en           = !(result_valid && result_stall);
	assign sample_stall = !en;

	// ---------------- roll: atan(Gy/Gz), de-rotate (Bz, By, Gz) ----------------
	logic signed [16:0]   gz17, gy17;
	logic signed [16:0]   x1, y1;
	logic signed [DW-1:0] c1_x, c1_y, c1_u, c1_v;
	sb1_t                 sb1;

	always_comb begin
		gz17        = 17'(sample.accel_z);
		gy17        = 17'(sample.accel_y);
		sb1.neg     = sample.accel_z[15];
		sb1.zero    = (sample.accel_z == 16'sd0);
		sb1.num_neg = sample.accel_y[15];
		sb1.num_pos = !sample.accel_y[15] && (sample.accel_y != 16'sd0);
		sb1.by      = sample.mag_y;
		sb1.bz      = sample.mag_z;
		sb1.bx      = sample.mag_x;
		sb1.gx      = sample.accel_x;
		sb1.gy      = sample.accel_y;
		// negative denominator: flip both master terms for the principal value
		x1   = sb1.neg ? -gz17 : gz17;
		y1   = sb1.neg ? -gy17 : gy17;
		c1_x = DW'(x1) <<< SH;
		c1_y = DW'(y1) <<< SH;
		c1_u = DW'(sample.mag_z) <<< SH;
		c1_v = DW'(sample.mag_y) <<< SH;
	end

	logic                 c1o_valid;
	logic signed [DW-1:0] c1o_x, c1o_u, c1o_v;
	logic signed [AW-1:0] c1o_acc;
	sb1_t                 c1o_sb;

	tcch_cordic #(.STEPS(CORDIC_STEPS), .DW(DW), .SBW($bits(sb1_t))) u_cordic_roll (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(sample_valid),
		.x(c1_x), .y(c1_y), .u(c1_u), .v(c1_v), .sb(sb1),
		.out_valid(c1o_valid), .x_res(c1o_x), .u_res(c1o_u), .v_res(c1o_v),
		.acc_res(c1o_acc), .sb_res(c1o_sb)
	);

	logic signed [DW-1:0] g1_w [3];
	sbg1_t                g1_sb;

	always_comb begin
		g1_w[0]    = c1o_u;
		g1_w[1]    = c1o_v;
		g1_w[2]    = c1o_sb.neg ? -c1o_x : c1o_x;
		g1_sb.roll = tcch_pkg::to_angle(c1o_acc);
		g1_sb.s    = c1o_sb;
	end

	logic                 g1o_valid;
	logic signed [RW-1:0] g1o_r [3];
	sbg1_t                g1o_sb;

	tcch_gain #(.NUM(3), .DW(DW), .RW(RW), .SBW($bits(sbg1_t))) u_gain_roll (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(c1o_valid),
		.w(g1_w), .sb(g1_sb), .out_valid(g1o_valid), .res(g1o_r), .sb_res(g1o_sb)
	);

	// special case: zero Gz is an exact quarter turn (or none)
	logic                 vld_s2;
	logic signed [15:0]   roll_s2, bx_s2, gx_s2;
	logic signed [RW-1:0] bz1_s2, bfy_s2, gz1_s2;
	logic signed [RW-1:0] by_r, bz_r, gy_r;

	always_comb begin
		by_r = RW'(g1o_sb.s.by);
		bz_r = RW'(g1o_sb.s.bz);
		gy_r = RW'(g1o_sb.s.gy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= g1o_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bx_s2 <= g1o_sb.s.bx;
			gx_s2 <= g1o_sb.s.gx;
			if (!g1o_sb.s.zero) begin
				roll_s2 <= g1o_sb.roll;
				bz1_s2  <= g1o_r[0];
				bfy_s2  <= g1o_r[1];
				gz1_s2  <= g1o_r[2];
			end else if (g1o_sb.s.num_neg) begin
				roll_s2 <= tcch_pkg::QUARTER;
				bz1_s2  <= by_r;
				bfy_s2  <= -bz_r;
				gz1_s2  <= gy_r;
			end else if (g1o_sb.s.num_pos) begin
				roll_s2 <= -tcch_pkg::QUARTER;
				bz1_s2  <= -by_r;
				bfy_s2  <= bz_r;
				gz1_s2  <= -gy_r;
			end else begin
				roll_s2 <= '0;
				bz1_s2  <= bz_r;
				bfy_s2  <= by_r;
				gz1_s2  <= '0;
			end
		end
	end

	// ---------------- pitch: atan(-Gx/Gz'), de-rotate (Bx, Bz') ----------------
	logic signed [RW:0]   gz1_e, x2;
	logic signed [16:0]   gx17, y2;
	logic signed [DW-1:0] c2_x, c2_y, c2_u, c2_v;
	logic                 n2;
	sb2_t                 sb2;

	always_comb begin
		gz1_e    = (RW+1)'(gz1_s2);
		gx17     = 17'(gx_s2);
		n2       = gz1_s2[RW-1];
		x2       = n2 ? -gz1_e : gz1_e;
		y2       = n2 ? gx17 : -gx17;
		c2_x     = DW'(x2) <<< SH;
		c2_y     = DW'(y2) <<< SH;
		c2_u     = DW'(bx_s2) <<< SH;
		c2_v     = DW'(bz1_s2) <<< SH;
		sb2.zero = (gz1_s2 == '0);
		sb2.roll = roll_s2;
		sb2.bfy  = bfy_s2;
		sb2.bz1  = bz1_s2;
		sb2.bx   = bx_s2;
		sb2.gx   = gx_s2;
	end

	logic                 c2o_valid;
	logic signed [DW-1:0] c2o_x, c2o_u, c2o_v;
	logic signed [AW-1:0] c2o_acc;
	sb2_t                 c2o_sb;

	tcch_cordic #(.STEPS(CORDIC_STEPS), .DW(DW), .SBW($bits(sb2_t))) u_cordic_pitch (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s2),
		.x(c2_x), .y(c2_y), .u(c2_u), .v(c2_v), .sb(sb2),
		.out_valid(c2o_valid), .x_res(c2o_x), .u_res(c2o_u), .v_res(c2o_v),
		.acc_res(c2o_acc), .sb_res(c2o_sb)
	);

	logic signed [DW-1:0] g2_w [1];
	sbg2_t                g2_sb;

	always_comb begin
		g2_w[0]     = c2o_u;
		g2_sb.pitch = tcch_pkg::to_angle(c2o_acc);
		g2_sb.s     = c2o_sb;
	end

	logic                 g2o_valid;
	logic signed [RW-1:0] g2o_r [1];
	sbg2_t                g2o_sb;

	tcch_gain #(.NUM(1), .DW(DW), .RW(RW), .SBW($bits(sbg2_t))) u_gain_pitch (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(c2o_valid),
		.w(g2_w), .sb(g2_sb), .out_valid(g2o_valid), .res(g2o_r), .sb_res(g2o_sb)
	);

	// Bfx may reach 2^(RW-1) when Bz' is negated, hence one extra bit
	logic                 vld_s3;
	logic signed [15:0]   roll_s3, pitch_s3;
	logic signed [RW:0]   bfx_s3;
	logic signed [RW-1:0] bfy_s3;
	logic signed [RW:0]   bz1_e;
	logic                 gx_neg, gx_pos;

	always_comb begin
		bz1_e  = (RW+1)'(g2o_sb.s.bz1);
		gx_neg = g2o_sb.s.gx[15];
		gx_pos = !g2o_sb.s.gx[15] && (g2o_sb.s.gx != 16'sd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= g2o_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s3 <= g2o_sb.s.roll;
			bfy_s3  <= g2o_sb.s.bfy;
			if (!g2o_sb.s.zero) begin
				pitch_s3 <= g2o_sb.pitch;
				bfx_s3   <= (RW+1)'(g2o_r[0]);
			end else if (gx_neg) begin
				pitch_s3 <= tcch_pkg::QUARTER;
				bfx_s3   <= bz1_e;
			end else if (gx_pos) begin
				pitch_s3 <= -tcch_pkg::QUARTER;
				bfx_s3   <= -bz1_e;
			end else begin
				pitch_s3 <= '0;
				bfx_s3   <= (RW+1)'(g2o_sb.s.bx);
			end
		end
	end

	// ---------------- heading: atan(-Bfy/Bfx) ----------------
	logic signed [RW+1:0] bfx_e, x3;
	logic signed [RW:0]   bfy_e, y3;
	logic signed [DW-1:0] c3_x, c3_y;
	logic                 n3;
	sb3_t                 sb3;

	always_comb begin
		bfx_e       = (RW+2)'(bfx_s3);
		bfy_e       = (RW+1)'(bfy_s3);
		n3          = bfx_s3[RW];
		x3          = n3 ? -bfx_e : bfx_e;
		y3          = n3 ? bfy_e : -bfy_e;
		c3_x        = DW'(x3) <<< SH;
		c3_y        = DW'(y3) <<< SH;
		sb3.zero    = (bfx_s3 == '0);
		sb3.num_neg = bfy_s3[RW-1];
		sb3.num_pos = !bfy_s3[RW-1] && (bfy_s3 != '0);
		sb3.roll    = roll_s3;
		sb3.pitch   = pitch_s3;
	end

	logic                 c3o_valid;
	logic signed [DW-1:0] c3o_x, c3o_u, c3o_v;
	logic signed [AW-1:0] c3o_acc;
	sb3_t                 c3o_sb;

	// no slave vector here; the unused lanes are trimmed by synthesis
	tcch_cordic #(.STEPS(CORDIC_STEPS), .DW(DW), .SBW($bits(sb3_t))) u_cordic_head (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(vld_s3),
		.x(c3_x), .y(c3_y), .u('0), .v('0), .sb(sb3),
		.out_valid(c3o_valid), .x_res(c3o_x), .u_res(c3o_u), .v_res(c3o_v),
		.acc_res(c3o_acc), .sb_res(c3o_sb)
	);

	// output register
	logic              result_valid_q;
	tcch_pkg::result_t result_q;
	logic signed [15:0] head_sel;

	always_comb begin
		if (!c3o_sb.zero) begin
			head_sel = tcch_pkg::to_angle(c3o_acc);
		end else if (c3o_sb.num_neg) begin
			head_sel = tcch_pkg::QUARTER;
		end else if (c3o_sb.num_pos) begin
			head_sel = -tcch_pkg::QUARTER;
		end else begin
			head_sel = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= c3o_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q.roll_angle    <= c3o_sb.roll;
			result_q.pitch_angle   <= c3o_sb.pitch;
			result_q.heading_angle <= head_sel;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ---------------- checks ----------------
	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.roll_angle <= 16'sd16384 &&
			result.roll_angle >= -16'sd16384))
		else $error("roll angle beyond a quarter turn");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.pitch_angle <= 16'sd16384 &&
			result.pitch_angle >= -16'sd16384))
		else $error("pitch angle beyond a quarter turn");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.heading_angle <= 16'sd16384 &&
			result.heading_angle >= -16'sd16384))
		else $error("heading angle beyond a quarter turn");

	a_zero_head: assert property (@(posedge clk) disable iff (!arst_n)
		(en && c3o_valid && c3o_sb.zero && !c3o_sb.num_neg && !c3o_sb.num_pos)
		|=> (result.heading_angle == 16'sd0))
		else $error("zero field vector must give zero heading");

endmodule

// File: hdl/tcch_cordic.sv
// Pipelined vectoring CORDIC, one micro-rotation per stage, slave vector alongside.
// Depends on tcch_pkg (arctangent table).
module tcch_cordic #(
	parameter int STEPS = tcch_pkg::CORDIC_STEPS_DEF,
	parameter int DW    = tcch_pkg::ROTATED_WIDTH_DEF + 20,
	parameter int SBW   = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [DW-1:0]          x,
	input  logic signed [DW-1:0]          y,
	input  logic signed [DW-1:0]          u,
	input  logic signed [DW-1:0]          v,
	input  logic [SBW-1:0]                sb,
	output logic                          out_valid,
	output logic signed [DW-1:0]          x_res,
	output logic signed [DW-1:0]          u_res,
	output logic signed [DW-1:0]          v_res,
	output logic signed [tcch_pkg::ANG_W-1:0] acc_res,
	output logic [SBW-1:0]                sb_res
);

	logic [STEPS:1]                       vld_s;
	logic signed [DW-1:0]                 x_s [1:STEPS];
	logic signed [DW-1:0]                 y_s [1:STEPS];
	logic signed [DW-1:0]                 u_s [1:STEPS];
	logic signed [DW-1:0]                 v_s [1:STEPS];
	logic signed [tcch_pkg::ANG_W-1:0]    acc_s [1:STEPS];
	logic [SBW-1:0]                       sb_s [1:STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic                          vc;
		logic signed [DW-1:0]          xc, yc, uc, vcs;
		logic signed [tcch_pkg::ANG_W-1:0] ac;
		logic [SBW-1:0]                sc;
		if (i == 0) begin : g_first
			assign vc  = in_valid;
			assign xc  = x;
			assign yc  = y;
			assign uc  = u;
			assign vcs = v;
			assign ac  = '0;
			assign sc  = sb;
		end else begin : g_next
			assign vc  = vld_s[i];
			assign xc  = x_s[i];
			assign yc  = y_s[i];
			assign uc  = u_s[i];
			assign vcs = v_s[i];
			assign ac  = acc_s[i];
			assign sc  = sb_s[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vc;
			end
		end

		// direction from the sign of y; shifts are floor shifts
		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[i+1] <= sc;
				if (yc >= 0) begin
					x_s[i+1]   <= xc + (yc >>> i);
					y_s[i+1]   <= yc - (xc >>> i);
					u_s[i+1]   <= uc + (vcs >>> i);
					v_s[i+1]   <= vcs - (uc >>> i);
					acc_s[i+1] <= ac + tcch_pkg::atan_entry(i);
				end else begin
					x_s[i+1]   <= xc - (yc >>> i);
					y_s[i+1]   <= yc + (xc >>> i);
					u_s[i+1]   <= uc - (vcs >>> i);
					v_s[i+1]   <= vcs + (uc >>> i);
					acc_s[i+1] <= ac - tcch_pkg::atan_entry(i);
				end
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign x_res     = x_s[STEPS];
	assign u_res     = u_s[STEPS];
	assign v_res     = v_s[STEPS];
	assign acc_res   = acc_s[STEPS];
	assign sb_res    = sb_s[STEPS];

endmodule

// File: hdl/tcch_gain.sv
// CORDIC gain compensation: multiply by KINV, round, shift by 40, saturate.
// Two stages: split partial products, then sum and clamp. Depends on tcch_pkg.
module tcch_gain #(
	parameter int NUM = 1,
	parameter int DW  = tcch_pkg::ROTATED_WIDTH_DEF + 20,
	parameter int RW  = tcch_pkg::ROTATED_WIDTH_DEF,
	parameter int SBW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [DW-1:0] w [NUM],
	input  logic [SBW-1:0]       sb,
	output logic                 out_valid,
	output logic signed [RW-1:0] res [NUM],
	output logic [SBW-1:0]       sb_res
);

	localparam int LW  = tcch_pkg::GAIN_LO_W;
	localparam int PLW = LW + 24;
	localparam int HW  = DW - LW;
	localparam int PHW = HW + 25;
	localparam int PW  = PHW + LW + 1;
	localparam logic signed [PW-1:0] RND  = PW'(1) << 39;
	localparam logic signed [PW-1:0] SMAX = (PW'(1) << (RW - 1)) - PW'(1);
	localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);

	logic                  vld_s1, vld_s2;
	logic [SBW-1:0]        sb_s1, sb_s2;
	logic [PLW-1:0]        plo_s1 [NUM];
	logic signed [PHW-1:0] phi_s1 [NUM];
	logic signed [RW-1:0]  res_s2 [NUM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s1 <= sb;
			sb_s2 <= sb_s1;
		end
	end

	for (genvar k = 0; k < NUM; k++) begin : g_lane
		logic signed [PW-1:0] sum;
		logic signed [PW-1:0] sh;

		always_ff @(posedge clk) begin
			if (en) begin
				plo_s1[k] <= PLW'(w[k][LW-1:0]) * PLW'(tcch_pkg::KINV);
				phi_s1[k] <= PHW'($signed(w[k][DW-1:LW])) *
					PHW'($signed({1'b0, tcch_pkg::KINV}));
			end
		end

		always_comb begin
			sum = (PW'(phi_s1[k]) <<< LW) + $signed(PW'(plo_s1[k])) + RND;
			sh  = sum >>> 40;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (sh > SMAX) begin
					res_s2[k] <= RW'(SMAX);
				end else if (sh < SMIN) begin
					res_s2[k] <= RW'(SMIN);
				end else begin
					res_s2[k] <= RW'(sh);
				end
			end
		end

		assign res[k] = res_s2[k];
	end

	assign out_valid = vld_s2;
	assign sb_res    = sb_s2;

endmodule

// File: verif/tilt_compensated_compass_heading_tb.sv
// Self-checking bench for tilt_compensated_compass_heading: directed table, then random sensor sets.
// Depends on tcch_pkg and the RTL of the block; predicts every result with its own CORDIC model.
`timescale 1ns / 100ps

module tilt_compensated_compass_heading_tb;

	localparam int STEPS     = 16;
	localparam int ROT_W     = 18;
	localparam int N_RANDOM  = 1330;
	localparam int LATENCY   = 3 * STEPS + 7;
	localparam longint LIMIT = 400000;

	logic              clk;
	logic              arst_n;
	logic              sample_valid;
	logic              sample_stall;
	tcch_pkg::sample_t sample;
	logic              result_valid;
	logic              result_stall;
	tcch_pkg::result_t result;

	tilt_compensated_compass_heading #(
		.CORDIC_STEPS(STEPS),
		.ROTATED_WIDTH(ROT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	// directed row: the sensor set, and a fixed answer where one is obvious
	typedef struct {
		tcch_pkg::sample_t s;
		bit                fixed;
		tcch_pkg::result_t r;
	} row_t;

	tcch_pkg::result_t angles_due[$];
	int      mismatches;
	longint  cycles;
	int      n_sent;
	int      n_checked;
	bit      sending_done;
	bit      long_hold;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor
	// floor shift of a signed value
	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp_rot(longint v);
		longint lim;
		lim = longint'(1) << (ROT_W - 1);
		if (v > lim - 1)
			return lim - 1;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// undo the CORDIC gain and round
	function automatic longint ungain(longint w);
		return clamp_rot(floor_shr(w * longint'(tcch_pkg::KINV) + (longint'(1) << 39), 40));
	endfunction

	function automatic longint acc_to_angle(longint a);
		longint r;
		r = floor_shr(a + (longint'(1) << 14), 15);
		if (r > 16384)
			r = 16384;
		if (r < -16384)
			r = -16384;
		return r;
	endfunction

	function automatic longint atan_step(int i);
		longint t [24];
		t = '{268435456, 158466703, 83729454, 42502378, 21333666, 10677233,
			5339919, 2670123, 1335082, 667543, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608,
			1304, 652, 326, 163, 81, 41};
		return t[i];
	endfunction

	// vectoring on (x,y), x>0, dragging (u,v) along; returns accumulated angle
	function automatic longint vector_rotate(longint x, longint y, inout longint u,
			inout longint v, output longint xo);
		longint bx, by, bu, bv, acc, dx, dy, du, dv;
		bx = x <<< 16;
		by = y <<< 16;
		bu = u <<< 16;
		bv = v <<< 16;
		acc = 0;
		for (int i = 0; i < STEPS && i < 24; i++) begin
			dx = floor_shr(by, i);
			dy = floor_shr(bx, i);
			du = floor_shr(bv, i);
			dv = floor_shr(bu, i);
			if (by >= 0) begin
				bx += dx; by -= dy; bu += du; bv -= dv; acc += atan_step(i);
			end else begin
				bx -= dx; by += dy; bu -= du; bv += dv; acc -= atan_step(i);
			end
		end
		u = bu;
		v = bv;
		xo = bx;
		return acc;
	endfunction

	function automatic longint sgn(longint v);
		return v > 0 ? 1 : (v < 0 ? -1 : 0);
	endfunction

	function automatic tcch_pkg::result_t predict_angles(tcch_pkg::sample_t s);
		longint bx, by, bz, gx, gy, gz;
		longint roll, pitch, head, bz1, bfy, gz1, bfx, u, v, xo, d;
		bit n;
		tcch_pkg::result_t r;
		bx = s.mag_x;   by = s.mag_y;   bz = s.mag_z;
		gx = s.accel_x; gy = s.accel_y; gz = s.accel_z;
		// roll
		if (gz == 0) begin
			d = sgn(-gy);
			roll = d * 16384;
			if (d > 0) begin
				bz1 = by; bfy = -bz; gz1 = gy;
			end else if (d < 0) begin
				bz1 = -by; bfy = bz; gz1 = -gy;
			end else begin
				bz1 = bz; bfy = by; gz1 = 0;
			end
		end else begin
			n = gz < 0;
			u = bz;
			v = by;
			roll = acc_to_angle(vector_rotate(n ? -gz : gz, n ? -gy : gy, u, v, xo));
			bz1 = ungain(u);
			bfy = ungain(v);
			gz1 = ungain(n ? -xo : xo);
		end
		// pitch
		if (gz1 == 0) begin
			d = sgn(-gx);
			pitch = d * 16384;
			bfx = d > 0 ? bz1 : (d < 0 ? -bz1 : bx);
		end else begin
			n = gz1 < 0;
			u = bx;
			v = bz1;
			pitch = acc_to_angle(vector_rotate(n ? -gz1 : gz1, n ? gx : -gx, u, v, xo));
			bfx = ungain(u);
		end
		// heading
		if (bfx == 0) begin
			head = sgn(-bfy) * 16384;
		end else begin
			n = bfx < 0;
			u = 0;
			v = 0;
			head = acc_to_angle(vector_rotate(n ? -bfx : bfx, n ? bfy : -bfy, u, v, xo));
		end
		r.roll_angle    = 16'(roll);
		r.pitch_angle   = 16'(pitch);
		r.heading_angle = 16'(head);
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus
	function automatic tcch_pkg::sample_t mk(int mx, int my, int mz, int ax, int ay, int az);
		tcch_pkg::sample_t s;
		s.mag_x = 16'(mx); s.mag_y = 16'(my); s.mag_z = 16'(mz);
		s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
		return s;
	endfunction

	function automatic tcch_pkg::result_t ang(int r, int p, int h);
		tcch_pkg::result_t a;
		a.roll_angle = 16'(r);
		a.pitch_angle = 16'(p);
		a.heading_angle = 16'(h);
		return a;
	endfunction

	function automatic logic signed [15:0] rnd_reading();
		case ($urandom_range(0, 9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'(0);
			3: return 16'($urandom_range(0, 64) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	// random sets, some with full-scale or small readings; some axes zeroed to hit the
	// divide-by-zero branches
	function automatic tcch_pkg::sample_t rnd_sample();
		tcch_pkg::sample_t s;
		s = tcch_pkg::sample_t'({$urandom, $urandom, $urandom});
		case ($urandom_range(0, 5))
			0: begin
				s.mag_x = rnd_reading(); s.mag_y = rnd_reading(); s.mag_z = rnd_reading();
				s.accel_x = rnd_reading(); s.accel_y = rnd_reading();
				s.accel_z = rnd_reading();
			end
			1: s.accel_z = '0;
			2: begin
				s.accel_z = '0;
				s.accel_y = '0;
			end
			3: begin
				s.mag_x = '0;
				s.mag_y = '0;
			end
			default: ;
		endcase
		return s;
	endfunction

	// entered at a falling edge; valid stays high across back-to-back transfers
	task automatic send_sample(tcch_pkg::sample_t s);
		int gap;
		gap = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 10)) : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		n_sent++;
		angles_due.push_back(predict_angles(s));
		@(negedge clk);
	endtask

	row_t rows [$];

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		mismatches = 0;
		n_sent = 0;
		sending_done = 0;
		// every-axis zero: all three angles fall to zero by the degenerate branches
		rows.push_back('{mk(0, 0, 0, 0, 0, 0), 1, ang(0, 0, 0)});
		// zero Gz, negative Gy: roll a positive quarter turn
		rows.push_back('{mk(0, 0, 0, 0, -100, 0), 0, ang(0, 0, 0)});
		rows.push_back('{mk(0, 0, 0, 0, 100, 0), 0, ang(0, 0, 0)});
		rows.push_back('{mk(100, 0, 0, 0, 0, 0), 1, ang(0, 0, 0)});
		rows.push_back('{mk(0, 100, 0, 0, 0, 0), 1, ang(0, 0, -16384)});
		rows.push_back('{mk(0, -100, 0, 0, 0, 0), 1, ang(0, 0, 16384)});
		rows.push_back('{mk(0, 0, 0, 100, 0, 0), 1, ang(0, -16384, 0)});
		rows.push_back('{mk(0, 0, 0, -100, 0, 0), 1, ang(0, 16384, 0)});
		rows.push_back('{mk(32767, 32767, 32767, 32767, 32767, 32767), 0, ang(0, 0, 0)});
		rows.push_back('{mk(-32768, -32768, -32768, -32768, -32768, -32768), 0, ang(0, 0, 0)});
		rows.push_back('{mk(32767, -32768, 32767, -32768, 32767, -32768), 0, ang(0, 0, 0)});
		rows.push_back('{mk(-32768, 32767, -32768, 32767, -32768, 32767), 0, ang(0, 0, 0)});
		rows.push_back('{mk(1000, 0, 0, 0, 0, 16384), 0, ang(0, 0, 0)});
		rows.push_back('{mk(-1000, 0, 0, 0, 0, 16384), 0, ang(0, 0, 0)});
		rows.push_back('{mk(1000, 500, -300, 200, -400, -16000), 0, ang(0, 0, 0)});
		rows.push_back('{mk(0, 0, 500, 0, 16000, 0), 0, ang(0, 0, 0)});
		rows.push_back('{mk(300, 200, 100, -8000, 1000, 14000), 0, ang(0, 0, 0)});
		rows.push_back('{mk(1, 1, 1, 1, 1, 1), 0, ang(0, 0, 0)});
		rows.push_back('{mk(-1, -1, -1, -1, -1, -1), 0, ang(0, 0, 0)});
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (rows[i]) begin
			// fixed answers must agree with the predictor too, a cheap sanity check
			if (rows[i].fixed && predict_angles(rows[i].s) != rows[i].r) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row %0d: typed answer %h disagrees with predictor %h",
						i, rows[i].r, predict_angles(rows[i].s));
			end
			send_sample(rows[i].s);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			send_sample(rnd_sample());
		end
		sample_valid <= 1'b0;
		sending_done = 1;
	end

	// ---------------------------------------------------------------- receiver
	initial begin
		result_stall = 1'b1;
		long_hold = 0;
		n_checked = 0;
		@(posedge arst_n);
		forever begin
			int hold;
			@(negedge clk);
			hold = 0;
			// one long hold once the pipeline has had time to fill
			if (!long_hold && n_sent > 200) begin
				long_hold = 1;
				hold = 300;
			end else if ($urandom_range(0, 3) == 0) begin
				hold = int'($urandom_range(0, 10));
			end
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			check_result(result);
		end
	end

	task automatic check_result(tcch_pkg::result_t got);
		tcch_pkg::result_t want;
		n_checked++;
		if (angles_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected transfer out: %h", got);
			return;
		end
		want = angles_due.pop_front();
		if (got.roll_angle !== want.roll_angle || got.pitch_angle !== want.pitch_angle ||
				got.heading_angle !== want.heading_angle) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: roll %0d/%0d pitch %0d/%0d heading %0d/%0d (exp/got)",
					n_checked, want.roll_angle, got.roll_angle, want.pitch_angle,
					got.pitch_angle, want.heading_angle, got.heading_angle);
		end
	endtask

	// ---------------------------------------------------------------- end of run
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("timeout after %0d cycles, %0d outstanding", cycles, angles_due.size());
				$display("tilt_compensated_compass_heading regression: fail");
				$finish;
			end
		end
	end

	initial begin
		wait (sending_done);
		wait (angles_due.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("%0d sensor sets sent, %0d results checked; zero-denominator branches,",
			n_sent, n_checked);
		$display("full-scale readings and a long output hold were exercised.");
		if (mismatches == 0 && angles_due.size() == 0)
			$display("tilt_compensated_compass_heading regression: pass");
		else
			$display("tilt_compensated_compass_heading regression: fail");
		$finish;
	end

endmodule
